>>> rtl/cvrp_pkg.sv
// Shared types, widths and codes for the tour cost evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cvrp_pkg;

	localparam int MAX_CLIENTS = 128;
	localparam int SLOT_W      = $clog2(MAX_CLIENTS);
	localparam int CLIENT_W    = 8;
	localparam int COORD_W     = 16;
	localparam int DEM_W       = 16;
	localparam int LOAD_W      = 24;
	localparam int DIST_W      = 32;
	localparam int TRIP_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int DIFF_W      = COORD_W + 1;
	localparam int SQ_W        = 2 * DIFF_W;
	localparam int ROOT_W      = DIFF_W;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_X  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_Y  = 2'd2;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TOUR = 1'b1;

	typedef struct packed {
		logic                       func;
		logic [CLIENT_W-1:0]        client_number;
		logic signed [COORD_W-1:0]  x_coord;
		logic signed [COORD_W-1:0]  y_coord;
		logic [DEM_W-1:0]           demand;
		logic                       last;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] total_distance;
		logic [TRIP_W-1:0] subtour_count;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [DEM_W-1:0]          demand;
	} entry_t;

	typedef enum logic [1:0] {
		LEG_CUR_PREV,
		LEG_PREV_DEPOT,
		LEG_CUR_DEPOT
	} leg_kind_t;

	typedef struct packed {
		logic      load_wr;
		logic      capture;
		logic      rd_prev;
		logic      cap_cur;
		logic      cap_prev;
		logic      update;
		leg_kind_t leg_kind;
		logic      leg_sub;
		logic      leg_mul;
		logic      root_start;
		logic      acc;
		logic      emit;
	} dp_cmd_t;

	typedef struct packed {
		logic tour_start;
		logic fits;
		logic last;
		logic root_done;
	} dp_status_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [CLIENT_W-1:0] client);
		logic [CLIENT_W-1:0] s;
		s = client - CLIENT_W'(1);
		slot_of = SLOT_W'(32'(s) % MAX_CLIENTS);
	endfunction

endpackage

>>> rtl/cvrp_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on cvrp_pkg for the radicand and root widths.
`timescale 1ns / 1ps
module cvrp_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cvrp_pkg::SQ_W-1:0]   radicand,
	output logic [cvrp_pkg::ROOT_W-1:0] root,
	output logic                        done
);

	localparam int REM_W = cvrp_pkg::ROOT_W + 2;
	localparam int CNT_W = $clog2(cvrp_pkg::ROOT_W + 1);

	logic [cvrp_pkg::SQ_W-1:0]   rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [cvrp_pkg::ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [REM_W+1:0]            trial_rem;
	logic [REM_W+1:0]            trial;
	logic [REM_W+1:0]            diff;
	logic                        ge;

	always_comb begin
		trial_rem = {rem_q, rad_q[cvrp_pkg::SQ_W-1 -: 2]};
		trial     = (REM_W + 2)'({root_q, 2'b01});
		ge        = trial_rem >= trial;
		diff      = trial_rem - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(cvrp_pkg::ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? REM_W'(diff) : REM_W'(trial_rem);
			root_q <= {root_q[cvrp_pkg::ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && busy_q))
		else $error("Square root started while still busy.");

endmodule

>>> rtl/cvrp_dp.sv
// Datapath: client tables, configuration, tour accumulators and the leg unit.
// Depends on cvrp_pkg and instantiates cvrp_isqrt.
`timescale 1ns / 1ps
module cvrp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cvrp_pkg::in_item_t              in_item,
	input  logic                            cfg_wr,
	input  logic [cvrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cvrp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  cvrp_pkg::dp_cmd_t               cmd,
	output cvrp_pkg::dp_status_t            status,
	output cvrp_pkg::out_item_t             out_item
);

	localparam int DW = cvrp_pkg::DIFF_W;

	cvrp_pkg::entry_t mem [cvrp_pkg::MAX_CLIENTS];
	cvrp_pkg::entry_t rdata_q;
	cvrp_pkg::entry_t cur_q;
	cvrp_pkg::entry_t prev_q;

	logic [cvrp_pkg::LOAD_W-1:0]         capacity_q;
	logic signed [cvrp_pkg::COORD_W-1:0] depot_x_q;
	logic signed [cvrp_pkg::COORD_W-1:0] depot_y_q;

	logic [cvrp_pkg::SLOT_W-1:0] slot_q;
	logic                        last_q;
	logic [cvrp_pkg::SLOT_W-1:0] prev_slot_q;
	logic [cvrp_pkg::LOAD_W-1:0] load_q;
	logic [cvrp_pkg::DIST_W-1:0] dist_q;
	logic [cvrp_pkg::TRIP_W-1:0] trip_q;
	logic                        start_q;
	cvrp_pkg::out_item_t         out_q;

	logic [cvrp_pkg::SLOT_W-1:0] rd_addr;
	logic [cvrp_pkg::LOAD_W:0]   load_sum;
	logic                        fits;
	logic signed [cvrp_pkg::COORD_W-1:0] ax, ay, bx, by;
	logic signed [DW-1:0]        dx_c, dy_c;
	logic signed [DW-1:0]        dx_s1, dy_s1;
	logic signed [2*DW-1:0]      sqx_s2, sqy_s2;
	logic [cvrp_pkg::SQ_W-1:0]   radicand;
	logic [cvrp_pkg::ROOT_W-1:0] root;
	logic                        root_done;
	logic [cvrp_pkg::DIST_W:0]   dist_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '1;
			depot_x_q  <= '0;
			depot_y_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				cvrp_pkg::CFG_CAPACITY: capacity_q <= cfg_data;
				cvrp_pkg::CFG_DEPOT_X:  depot_x_q  <= cfg_data[cvrp_pkg::COORD_W-1:0];
				cvrp_pkg::CFG_DEPOT_Y:  depot_y_q  <= cfg_data[cvrp_pkg::COORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign rd_addr = cmd.rd_prev ? prev_slot_q : slot_q;

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem[cvrp_pkg::slot_of(in_item.client_number)] <=
				'{x: in_item.x_coord, y: in_item.y_coord, demand: in_item.demand};
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q <= cvrp_pkg::slot_of(in_item.client_number);
			last_q <= in_item.last;
		end
		if (cmd.cap_cur) begin
			cur_q <= rdata_q;
		end
		if (cmd.cap_prev) begin
			prev_q <= rdata_q;
		end
		if (cmd.emit) begin
			out_q <= '{total_distance: dist_q, subtour_count: trip_q};
		end
	end

	always_comb begin
		load_sum = {1'b0, load_q} + (cvrp_pkg::LOAD_W + 1)'(cur_q.demand);
		fits     = load_sum <= {1'b0, capacity_q};
	end

	always_comb begin
		case (cmd.leg_kind)
			cvrp_pkg::LEG_CUR_PREV: begin
				ax = cur_q.x;
				ay = cur_q.y;
				bx = prev_q.x;
				by = prev_q.y;
			end
			cvrp_pkg::LEG_PREV_DEPOT: begin
				ax = prev_q.x;
				ay = prev_q.y;
				bx = depot_x_q;
				by = depot_y_q;
			end
			default: begin
				ax = cur_q.x;
				ay = cur_q.y;
				bx = depot_x_q;
				by = depot_y_q;
			end
		endcase
		dx_c = DW'(ax) - DW'(bx);
		dy_c = DW'(ay) - DW'(by);
	end

	always_ff @(posedge clk) begin
		if (cmd.leg_sub) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
		end
		if (cmd.leg_mul) begin
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
		end
	end

	assign radicand = $unsigned(sqx_s2) + $unsigned(sqy_s2);

	cvrp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (radicand),
		.root     (root),
		.done     (root_done)
	);

	assign dist_sum = {1'b0, dist_q} + (cvrp_pkg::DIST_W + 1)'(root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q      <= '0;
			dist_q      <= '0;
			trip_q      <= '0;
			prev_slot_q <= '0;
			start_q     <= 1'b1;
		end else begin
			if (cmd.update) begin
				prev_slot_q <= slot_q;
				if (start_q) begin
					load_q  <= cvrp_pkg::LOAD_W'(cur_q.demand);
					trip_q  <= cvrp_pkg::TRIP_W'(1);
					start_q <= 1'b0;
				end else if (fits) begin
					load_q <= load_sum[cvrp_pkg::LOAD_W-1:0];
				end else begin
					load_q <= cvrp_pkg::LOAD_W'(cur_q.demand);
					if (trip_q != '1) begin
						trip_q <= trip_q + cvrp_pkg::TRIP_W'(1);
					end
				end
			end
			if (cmd.acc) begin
				dist_q <= dist_sum[cvrp_pkg::DIST_W] ? '1 : dist_sum[cvrp_pkg::DIST_W-1:0];
			end
			if (cmd.emit) begin
				load_q      <= '0;
				dist_q      <= '0;
				trip_q      <= '0;
				prev_slot_q <= '0;
				start_q     <= 1'b1;
			end
		end
	end

	assign status = '{tour_start: start_q, fits: fits, last: last_q, root_done: root_done};
	assign out_item = out_q;

endmodule

>>> rtl/cvrp_ctrl.sv
// Controller: sequences table reads, leg computations and result hand-off.
// Depends on cvrp_pkg for the command and status structs.
`timescale 1ns / 1ps
module cvrp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_func,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  cvrp_pkg::dp_status_t status,
	output cvrp_pkg::dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_CUR,
		S_RD_PREV,
		S_DECIDE,
		S_LEG_SUB,
		S_LEG_MUL,
		S_LEG_ROOT,
		S_LEG_WAIT,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	logic                pend_pd_q;
	logic                pend_cp_q;
	logic [1:0]          cd_cnt_q;
	logic                in_acc;
	logic                emit_go;
	logic                more_legs;
	cvrp_pkg::leg_kind_t next_kind;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign emit_go   = !out_valid_q || out_ready;
	assign more_legs = pend_pd_q || pend_cp_q || (cd_cnt_q != 2'd0);
	assign next_kind = pend_pd_q ? cvrp_pkg::LEG_PREV_DEPOT :
		pend_cp_q ? cvrp_pkg::LEG_CUR_PREV : cvrp_pkg::LEG_CUR_DEPOT;

	always_comb begin
		cmd = '0;
		cmd.leg_kind = cvrp_pkg::LEG_CUR_DEPOT;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_wr = in_acc && (in_func == cvrp_pkg::FUNC_LOAD);
				cmd.capture = in_acc && (in_func == cvrp_pkg::FUNC_TOUR);
			end
			S_RD_CUR: ;
			S_RD_PREV: begin
				cmd.cap_cur = 1'b1;
				cmd.rd_prev = 1'b1;
			end
			S_DECIDE: begin
				cmd.cap_prev = 1'b1;
				cmd.update   = 1'b1;
			end
			S_LEG_SUB: begin
				cmd.leg_sub  = 1'b1;
				cmd.leg_kind = next_kind;
			end
			S_LEG_MUL:  cmd.leg_mul    = 1'b1;
			S_LEG_ROOT: cmd.root_start = 1'b1;
			S_LEG_WAIT: cmd.acc        = status.root_done;
			S_EMIT:     cmd.emit       = emit_go;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			pend_pd_q   <= 1'b0;
			pend_cp_q   <= 1'b0;
			cd_cnt_q    <= 2'd0;
		end else begin
			if (out_valid_q && out_ready && !cmd.emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (in_func == cvrp_pkg::FUNC_TOUR)) begin
						state_q <= S_RD_CUR;
					end
				end
				S_RD_CUR:  state_q <= S_RD_PREV;
				S_RD_PREV: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (status.tour_start) begin
						pend_pd_q <= 1'b0;
						pend_cp_q <= 1'b0;
						cd_cnt_q  <= status.last ? 2'd2 : 2'd1;
					end else if (status.fits) begin
						pend_pd_q <= 1'b0;
						pend_cp_q <= 1'b1;
						cd_cnt_q  <= status.last ? 2'd1 : 2'd0;
					end else begin
						pend_pd_q <= 1'b1;
						pend_cp_q <= 1'b0;
						cd_cnt_q  <= status.last ? 2'd2 : 2'd1;
					end
					state_q <= S_LEG_SUB;
				end
				S_LEG_SUB: begin
					if (pend_pd_q) begin
						pend_pd_q <= 1'b0;
					end else if (pend_cp_q) begin
						pend_cp_q <= 1'b0;
					end else begin
						cd_cnt_q <= cd_cnt_q - 2'd1;
					end
					state_q <= S_LEG_MUL;
				end
				S_LEG_MUL:  state_q <= S_LEG_ROOT;
				S_LEG_ROOT: state_q <= S_LEG_WAIT;
				S_LEG_WAIT: begin
					if (status.root_done) begin
						if (more_legs) begin
							state_q <= S_LEG_SUB;
						end else if (status.last) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.root_done |-> (state_q == S_LEG_WAIT))
		else $error("Square root finished outside the wait state.");

	a_leg_planned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |=> (pend_pd_q || pend_cp_q || (cd_cnt_q != 2'd0)))
		else $error("Tour request decided with no leg to compute.");

	a_cd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cd_cnt_q != 2'd3)
		else $error("Too many depot legs pending.");

endmodule

>>> rtl/cvrp_tour_cost_evaluator_top.sv
// Top level of the tour cost evaluator: joins controller and datapath.
// Depends on cvrp_pkg, cvrp_ctrl and cvrp_dp.
//
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    in_data (cvrp_pkg::in_item_t)
// out       result     out_valid / out_ready  out_data (cvrp_pkg::out_item_t)
// cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load request is written into the client table as it is accepted. A tour request
// reads the client tables, then computes one to three legs, each by a subtract, a
// multiply and an iterative square root run, before the next request is taken.
// Reset is asynchronous and active low; the client tables are not cleared.
// A finished result waits in the output register while new requests are taken;
// a second result waits for the first to be taken.
`timescale 1ns / 1ps
module cvrp_tour_cost_evaluator_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cvrp_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cvrp_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cvrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cvrp_pkg::CFG_DATA_W-1:0] cfg_data
);

	cvrp_pkg::dp_cmd_t    cmd;
	cvrp_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	cvrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (in_data.func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	cvrp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_data),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_item  (out_data)
	);

endmodule
